// File: rtl/core/i2c_pkg.sv
// ============================================================================
// i2c_pkg
// Shared widths, register indexes, command codes and clamp helpers for the
// image-to-column unroller.
// ============================================================================
package i2c_pkg;

    // Field and datapath widths
    localparam int DIM_W  = 7;   // channels, height, width (1..64)
    localparam int KER_W  = 4;   // kernel side, stride (1..15)
    localparam int CNT_W  = 6;   // walk counters
    localparam int PROD_W = 10;  // counter times stride
    localparam int IMG_W  = 11;  // image coordinate before range check
    localparam int BASE_W = 12;  // channel-row linear index
    localparam int SRC_W  = 19;  // full source pixel index
    localparam int IDX_W  = 3;

    typedef logic [IDX_W-1:0] cfg_idx_t;
    typedef logic [DIM_W-1:0] cfg_data_t;
    typedef logic [DIM_W-1:0] dim_t;
    typedef logic [KER_W-1:0] ker_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Configuration register indexes
    localparam cfg_idx_t REG_CHANNELS = 3'd0;
    localparam cfg_idx_t REG_HEIGHT   = 3'd1;
    localparam cfg_idx_t REG_WIDTH    = 3'd2;
    localparam cfg_idx_t REG_KSIZE    = 3'd3;
    localparam cfg_idx_t REG_STRIDE   = 3'd4;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    localparam dim_t DIM_MAX = 7'd64;

    // Map zero to one and cap at the largest supported dimension
    function automatic dim_t clamp_dim(dim_t v);
        dim_t r;
        r = v;
        if (v == '0)
            r = 7'd1;
        else if (v > DIM_MAX)
            r = DIM_MAX;
        return r;
    endfunction

    // Map zero to one for kernel side and stride
    function automatic ker_t clamp_ker(ker_t v);
        return (v == '0) ? 4'd1 : v;
    endfunction

endpackage

// File: rtl/core/i2c_ram.sv
// ============================================================================
// i2c_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ============================================================================
module i2c_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/image_to_column_unroller.sv
// ============================================================================
// image_to_column_unroller
// im2col for two-share images: loads pixel pairs into two image stores and
// walks the column matrix one element per emit command.
// ============================================================================
// Usage:
// - Input channel (in_valid/in_ready): cmd selects load (store the next
//   pixel pair in channel, row, column order) or emit (give the next
//   column-matrix element). Every item yields exactly one result item.
// - Output channel (out_valid/out_ready): shares, is_data, last_element and
//   overflow_flag. A load returns zero shares with overflow_flag set when
//   the store was already full and the pixel was dropped.
// - Config channel (cfg_valid/cfg_ready): always ready; cfg_index selects
//   channels, height, width, kernel side or stride. Write only while idle.
// - Results: a load result is registered in the cycle after acceptance.
//   An emit result passes products, image coordinates, source address,
//   store read, then the output register, which waits for a free slot.
// - Throughput: one load per cycle while results drain; an emit must pass
//   the five sequencer steps and return to idle before the next item is
//   taken, since the sequencer owns the store read port.
// - After the last element the walk restarts and the load pointer returns
//   to zero for the next image. Reset clears counters and pointer and loads
//   the register defaults; store contents stay undefined until loaded.
// - A stalled output holds its item; a load is still taken while the held
//   item drains in the same cycle, an emit is taken and finished behind it.
// ============================================================================
module image_to_column_unroller #(
    parameter int STORE_DEPTH = 4096,
    parameter int SHARE_BITS  = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // Input items
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      cmd,
    input  logic [SHARE_BITS-1:0]     share_in_a,
    input  logic [SHARE_BITS-1:0]     share_in_b,
    // Result items
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [SHARE_BITS-1:0]     share_out_a,
    output logic [SHARE_BITS-1:0]     share_out_b,
    output logic                      is_data,
    output logic                      last_element,
    output logic                      overflow_flag,
    // Configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  i2c_pkg::cfg_idx_t         cfg_index,
    input  i2c_pkg::cfg_data_t        cfg_data
);

    import i2c_pkg::*;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int PTR_W  = $clog2(STORE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LIN,
        ST_ADDR,
        ST_READ,
        ST_DATA
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    dim_t chan_cfg_reg, chan_cfg_next;
    dim_t height_cfg_reg, height_cfg_next;
    dim_t width_cfg_reg, width_cfg_next;
    ker_t ksize_cfg_reg, ksize_cfg_next;
    ker_t stride_cfg_reg, stride_cfg_next;

    // Walk counters and load pointer
    cnt_t ocol_reg, ocol_next;
    cnt_t orow_reg, orow_next;
    ker_t kcol_reg, kcol_next;
    ker_t krow_reg, krow_next;
    cnt_t src_ch_reg, src_ch_next;
    logic [PTR_W-1:0] load_ptr_reg, load_ptr_next;

    // Address sequencer registers
    logic [PROD_W-1:0] ocol_prod_reg, ocol_prod_next;
    logic [PROD_W-1:0] orow_prod_reg, orow_prod_next;
    logic [BASE_W-1:0] chan_base_reg, chan_base_next;
    logic [BASE_W-1:0] row_lin_reg, row_lin_next;
    cnt_t              im_col_lo_reg, im_col_lo_next;
    logic              in_img_reg, in_img_next;
    logic              last_reg, last_next;
    logic [ADDR_W-1:0] src_addr_reg, src_addr_next;
    logic              fetch_ok_reg, fetch_ok_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [SHARE_BITS-1:0] out_a_reg, out_a_next;
    logic [SHARE_BITS-1:0] out_b_reg, out_b_next;
    logic                  is_data_reg, is_data_next;
    logic                  last_out_reg, last_out_next;
    logic                  ovf_reg, ovf_next;

    // Combinational helpers
    dim_t chn, hgt, wid;
    ker_t ksc, stc;
    logic out_free;
    logic in_accept;
    logic store_full;
    logic wr_en;
    logic rd_en;
    logic [SHARE_BITS-1:0] rd_a, rd_b;
    logic [IMG_W-1:0] im_row, im_col;
    logic [IMG_W-1:0] reach_col, reach_row;
    logic wrap_oc, wrap_or, wrap_kc, wrap_kr, wrap_ch;
    logic [SRC_W-1:0] src_idx;

    // Effective register values
    assign chn = clamp_dim(chan_cfg_reg);
    assign hgt = clamp_dim(height_cfg_reg);
    assign wid = clamp_dim(width_cfg_reg);
    assign ksc = clamp_ker(ksize_cfg_reg);
    assign stc = clamp_ker(stride_cfg_reg);

    // Handshakes
    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == ST_IDLE) && ((cmd == CMD_EMIT) || out_free);
    assign in_accept  = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign store_full = (load_ptr_reg == PTR_W'(STORE_DEPTH));
    assign wr_en      = in_accept && (cmd == CMD_LOAD) && !store_full;
    assign rd_en      = (state_reg == ST_READ);

    // Image coordinates and wrap tests from the registered products
    assign im_row    = IMG_W'(krow_reg) + IMG_W'(orow_prod_reg);
    assign im_col    = IMG_W'(kcol_reg) + IMG_W'(ocol_prod_reg);
    assign reach_col = IMG_W'(ocol_prod_reg) + IMG_W'(stc) + IMG_W'(ksc);
    assign reach_row = IMG_W'(orow_prod_reg) + IMG_W'(stc) + IMG_W'(ksc);
    assign wrap_oc   = reach_col > IMG_W'(wid);
    assign wrap_or   = reach_row > IMG_W'(hgt);
    assign wrap_kc   = ({1'b0, kcol_reg} + 5'd1) >= {1'b0, ksc};
    assign wrap_kr   = ({1'b0, krow_reg} + 5'd1) >= {1'b0, ksc};
    assign wrap_ch   = ({1'b0, src_ch_reg} + 7'd1) >= chn;

    // Source pixel index
    assign src_idx = SRC_W'(wid) * SRC_W'(row_lin_reg) + SRC_W'(im_col_lo_reg);

    // Image stores, one per share
    i2c_ram #(
        .WIDTH (SHARE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store_a (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (load_ptr_reg[ADDR_W-1:0]),
        .wr_data (share_in_a),
        .rd_en   (rd_en),
        .rd_addr (src_addr_reg),
        .rd_data (rd_a)
    );

    i2c_ram #(
        .WIDTH (SHARE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store_b (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (load_ptr_reg[ADDR_W-1:0]),
        .wr_data (share_in_b),
        .rd_en   (rd_en),
        .rd_addr (src_addr_reg),
        .rd_data (rd_b)
    );

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        chan_cfg_next   = chan_cfg_reg;
        height_cfg_next = height_cfg_reg;
        width_cfg_next  = width_cfg_reg;
        ksize_cfg_next  = ksize_cfg_reg;
        stride_cfg_next = stride_cfg_reg;
        ocol_next       = ocol_reg;
        orow_next       = orow_reg;
        kcol_next       = kcol_reg;
        krow_next       = krow_reg;
        src_ch_next     = src_ch_reg;
        load_ptr_next   = load_ptr_reg;
        ocol_prod_next  = ocol_prod_reg;
        orow_prod_next  = orow_prod_reg;
        chan_base_next  = chan_base_reg;
        row_lin_next    = row_lin_reg;
        im_col_lo_next  = im_col_lo_reg;
        in_img_next     = in_img_reg;
        last_next       = last_reg;
        src_addr_next   = src_addr_reg;
        fetch_ok_next   = fetch_ok_reg;
        out_valid_next  = out_valid_reg;
        out_a_next      = out_a_reg;
        out_b_next      = out_b_reg;
        is_data_next    = is_data_reg;
        last_out_next   = last_out_reg;
        ovf_next        = ovf_reg;

        // Drop the held item once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Register writes
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CHANNELS: chan_cfg_next   = cfg_data;
                REG_HEIGHT:   height_cfg_next = cfg_data;
                REG_WIDTH:    width_cfg_next  = cfg_data;
                REG_KSIZE:    ksize_cfg_next  = cfg_data[KER_W-1:0];
                REG_STRIDE:   stride_cfg_next = cfg_data[KER_W-1:0];
                default:      ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (cmd == CMD_EMIT)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        // Store the pixel pair or flag the drop
                        if (!store_full)
                        begin
                            load_ptr_next = load_ptr_reg + PTR_W'(1);
                        end
                        out_valid_next = 1'b1;
                        out_a_next     = '0;
                        out_b_next     = '0;
                        is_data_next   = 1'b0;
                        last_out_next  = 1'b0;
                        ovf_next       = store_full;
                    end
                end
            end

            ST_MUL:
            begin
                // Offsets of the output position and the channel base row
                ocol_prod_next = PROD_W'(ocol_reg) * PROD_W'(stc);
                orow_prod_next = PROD_W'(orow_reg) * PROD_W'(stc);
                chan_base_next = BASE_W'(hgt) * BASE_W'(src_ch_reg);
                state_next     = ST_LIN;
            end

            ST_LIN:
            begin
                in_img_next    = (im_row < IMG_W'(hgt)) && (im_col < IMG_W'(wid));
                row_lin_next   = BASE_W'(im_row[CNT_W-1:0]) + chan_base_reg;
                im_col_lo_next = im_col[CNT_W-1:0];
                last_next      = wrap_oc && wrap_or && wrap_kc && wrap_kr && wrap_ch;

                // Advance the walk, innermost counter first
                ocol_next = wrap_oc ? '0 : ocol_reg + CNT_W'(1);
                if (wrap_oc)
                begin
                    orow_next = wrap_or ? '0 : orow_reg + CNT_W'(1);
                    if (wrap_or)
                    begin
                        kcol_next = wrap_kc ? '0 : kcol_reg + KER_W'(1);
                        if (wrap_kc)
                        begin
                            krow_next = wrap_kr ? '0 : krow_reg + KER_W'(1);
                            if (wrap_kr)
                            begin
                                src_ch_next = wrap_ch ? '0 : src_ch_reg + CNT_W'(1);
                            end
                        end
                    end
                end

                // Rewind the load pointer for the next image
                if (wrap_oc && wrap_or && wrap_kc && wrap_kr && wrap_ch)
                begin
                    load_ptr_next = '0;
                end
                state_next = ST_ADDR;
            end

            ST_ADDR:
            begin
                src_addr_next = src_idx[ADDR_W-1:0];
                fetch_ok_next = in_img_reg && (src_idx < SRC_W'(STORE_DEPTH));
                state_next    = ST_READ;
            end

            ST_READ:
            begin
                state_next = ST_DATA;
            end

            ST_DATA:
            begin
                // Hand the element over once the output slot is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_a_next     = fetch_ok_reg ? rd_a : '0;
                    out_b_next     = fetch_ok_reg ? rd_b : '0;
                    is_data_next   = 1'b1;
                    last_out_next  = last_reg;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            chan_cfg_reg   <= 7'd1;
            height_cfg_reg <= 7'd8;
            width_cfg_reg  <= 7'd8;
            ksize_cfg_reg  <= 4'd3;
            stride_cfg_reg <= 4'd1;
            ocol_reg       <= '0;
            orow_reg       <= '0;
            kcol_reg       <= '0;
            krow_reg       <= '0;
            src_ch_reg     <= '0;
            load_ptr_reg   <= '0;
            ocol_prod_reg  <= '0;
            orow_prod_reg  <= '0;
            chan_base_reg  <= '0;
            row_lin_reg    <= '0;
            im_col_lo_reg  <= '0;
            in_img_reg     <= 1'b0;
            last_reg       <= 1'b0;
            src_addr_reg   <= '0;
            fetch_ok_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_a_reg      <= '0;
            out_b_reg      <= '0;
            is_data_reg    <= 1'b0;
            last_out_reg   <= 1'b0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            chan_cfg_reg   <= chan_cfg_next;
            height_cfg_reg <= height_cfg_next;
            width_cfg_reg  <= width_cfg_next;
            ksize_cfg_reg  <= ksize_cfg_next;
            stride_cfg_reg <= stride_cfg_next;
            ocol_reg       <= ocol_next;
            orow_reg       <= orow_next;
            kcol_reg       <= kcol_next;
            krow_reg       <= krow_next;
            src_ch_reg     <= src_ch_next;
            load_ptr_reg   <= load_ptr_next;
            ocol_prod_reg  <= ocol_prod_next;
            orow_prod_reg  <= orow_prod_next;
            chan_base_reg  <= chan_base_next;
            row_lin_reg    <= row_lin_next;
            im_col_lo_reg  <= im_col_lo_next;
            in_img_reg     <= in_img_next;
            last_reg       <= last_next;
            src_addr_reg   <= src_addr_next;
            fetch_ok_reg   <= fetch_ok_next;
            out_valid_reg  <= out_valid_next;
            out_a_reg      <= out_a_next;
            out_b_reg      <= out_b_next;
            is_data_reg    <= is_data_next;
            last_out_reg   <= last_out_next;
            ovf_reg        <= ovf_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign share_out_a   = out_a_reg;
    assign share_out_b   = out_b_reg;
    assign is_data       = is_data_reg;
    assign last_element  = last_out_reg;
    assign overflow_flag = ovf_reg;

`ifndef SYNTH
    // No new item while an emit owns the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("item accepted while sequencer busy");

    // Last element is always a data item
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_element) |-> (is_data && !overflow_flag))
        else $error("last flag on a non-data item");

    // A load into a full store reports overflow next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (cmd == CMD_LOAD) && store_full)
        |=> (out_valid && overflow_flag && !is_data))
        else $error("dropped load not flagged");

    // Finishing the walk rewinds all counters and the load pointer
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_LIN) && wrap_oc && wrap_or && wrap_kc && wrap_kr && wrap_ch)
        |=> ((load_ptr_reg == '0) && (ocol_reg == '0) && (orow_reg == '0)
             && (kcol_reg == '0) && (krow_reg == '0) && (src_ch_reg == '0)))
        else $error("walk did not restart after last element");
`endif

endmodule
